// File: hw/rtl/charge_port_current_monitor_top_defines.svh
// Assertion macros shared by the charge port current monitor RTL.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef CHARGE_PORT_CURRENT_MONITOR_TOP_DEFINES_SVH
`define CHARGE_PORT_CURRENT_MONITOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cpcm_pkg.sv
`default_nettype none

package cpcm_pkg;

    // Number of monitored ports; status bit fields report ports 0..2 only.
    localparam int unsigned NUM_PORTS = 3;
    localparam int unsigned STAT_BITS = 3;

    // Field widths.
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned PORT_W  = 2;
    localparam int unsigned ADC_W   = 12;
    localparam int unsigned MA_W    = 12;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned QUO_W   = 21;
    localparam int unsigned BLINK_W = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IW  = 2;

    // Current scaling: mA = 13 * raw / 16.
    localparam int unsigned MA_MUL   = 13;
    localparam int unsigned MA_SHIFT = 4;
    localparam int unsigned MA_PW    = ADC_W + MA_SHIFT;

    // Blink count: mA / 100 = floor(13 * raw / 1600), taken as a reciprocal
    // product that is exact over the whole 12-bit raw range.
    localparam int unsigned DIV_SHIFT = 24;
    localparam int unsigned DIV_MULW  = 18;
    localparam int unsigned DIV_MUL   = 136315;
    localparam int unsigned DIV_PW    = ADC_W + DIV_MULW;
    localparam int unsigned DIV_W     = DIV_PW - DIV_SHIFT;

    // Charge is kept as quotient and remainder of a 32-bit wrapping
    // accumulator divided by 3600.
    localparam int unsigned   CHG_DIV_I = 3600;
    localparam longint unsigned ACC_MOD = 64'd1 << 32;
    localparam logic [MA_W:0]    CHG_DIV  = (MA_W + 1)'(CHG_DIV_I);
    localparam logic [QUO_W-1:0] CHG_QMAX = QUO_W'(ACC_MOD / CHG_DIV_I);
    localparam logic [MA_W:0]    CHG_WRAP = (MA_W + 1)'(ACC_MOD % CHG_DIV_I);

    // Blink pause length in blink ticks.
    localparam logic [BLINK_W-1:0] PAUSE_TICKS = BLINK_W'(2);

    // Configuration register reset values.
    localparam logic [MA_W-1:0]  CUT_MA_RST    = MA_W'(100);
    localparam logic [CNT_W-1:0] CUT_TICKS_RST = CNT_W'(230);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 3'd0,
        FUNC_SECOND = 3'd1,
        FUNC_BLINK  = 3'd2,
        FUNC_PRESS  = 3'd3,
        FUNC_TOGGLE = 3'd4
    } t_func;

    typedef enum logic [CFG_IW-1:0] {
        CFG_CUT_MA    = 2'd0,
        CFG_CUT_TICKS = 2'd1
    } t_cfg_reg;

    // Event broadcast from the top level to every port lane.
    typedef struct packed {
        logic              step;
        t_func             func;
        logic [MA_W-1:0]   ma;
        logic [DIV_W-1:0]  div;
        logic [MA_W-1:0]   cut_ma;
        logic [CNT_W-1:0]  cut_ticks;
    } t_lane_evt;

    // Post-event status of one lane.
    typedef struct packed {
        logic              out_on;
        logic              led_on;
        logic              auto_on;
        logic [MA_W-1:0]   current;
        logic [QUO_W-1:0]  charge;
    } t_lane_stat;

endpackage

`default_nettype wire

// File: hw/rtl/cpcm_port_lane.sv
`default_nettype none
`include "charge_port_current_monitor_top_defines.svh"

module cpcm_port_lane (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cpcm_pkg::t_lane_evt   i_evt,
    input  wire logic                  i_sel,
    output cpcm_pkg::t_lane_stat       o_stat
);

    logic [cpcm_pkg::MA_W-1:0]    r_cur,    n_cur;
    logic [cpcm_pkg::DIV_W-1:0]   r_div,    n_div;
    logic [cpcm_pkg::CNT_W-1:0]   r_below,  n_below;
    logic                         r_auto,   n_auto;
    logic                         r_out_on, n_out_on;
    logic                         r_led,    n_led;
    logic [cpcm_pkg::QUO_W-1:0]   r_quo,    n_quo;
    logic [cpcm_pkg::MA_W-1:0]    r_rem,    n_rem;
    logic [cpcm_pkg::BLINK_W-1:0] r_phase,  n_phase;
    logic [cpcm_pkg::BLINK_W-1:0] r_pause,  n_pause;

    logic [cpcm_pkg::MA_W:0]      sum;
    logic [cpcm_pkg::MA_W:0]      rem_c;
    logic [cpcm_pkg::QUO_W-1:0]   quo_c;
    logic [cpcm_pkg::BLINK_W-1:0] phase_inc;
    logic [cpcm_pkg::BLINK_W-1:0] pause_inc;
    logic [cpcm_pkg::CNT_W-1:0]   below_inc;

    // Charge step: remainder plus current stays below twice the divisor, so
    // one compare-subtract normalizes it; the 32-bit wrap is a second one.
    always_comb begin
        sum = {1'b0, r_rem} + {1'b0, r_cur};
        if (sum >= cpcm_pkg::CHG_DIV) begin
            rem_c = sum - cpcm_pkg::CHG_DIV;
            quo_c = r_quo + cpcm_pkg::QUO_W'(1);
        end else begin
            rem_c = sum;
            quo_c = r_quo;
        end
    end

    assign phase_inc = r_phase + cpcm_pkg::BLINK_W'(1);
    assign pause_inc = r_pause + cpcm_pkg::BLINK_W'(1);
    assign below_inc = (r_below == '1) ? r_below : r_below + cpcm_pkg::CNT_W'(1);

    always_comb begin
        n_cur    = r_cur;
        n_div    = r_div;
        n_below  = r_below;
        n_auto   = r_auto;
        n_out_on = r_out_on;
        n_led    = r_led;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_phase  = r_phase;
        n_pause  = r_pause;
        if (i_evt.step) begin
            case (i_evt.func)
                cpcm_pkg::FUNC_SAMPLE: begin
                    if (i_sel) begin
                        n_cur = i_evt.ma;
                        n_div = i_evt.div;
                        if (r_auto) begin
                            if (i_evt.ma < i_evt.cut_ma) begin
                                n_below = below_inc;
                                if (below_inc >= i_evt.cut_ticks) begin
                                    n_out_on = 1'b0;
                                end
                            end else begin
                                n_below = '0;
                            end
                        end
                    end
                end
                cpcm_pkg::FUNC_SECOND: begin
                    if (r_quo == cpcm_pkg::CHG_QMAX) begin
                        if (sum >= cpcm_pkg::CHG_WRAP) begin
                            n_quo = '0;
                            n_rem = cpcm_pkg::MA_W'(sum - cpcm_pkg::CHG_WRAP);
                        end else begin
                            n_rem = cpcm_pkg::MA_W'(sum);
                        end
                    end else if (quo_c == cpcm_pkg::CHG_QMAX &&
                                 rem_c >= cpcm_pkg::CHG_WRAP) begin
                        n_quo = '0;
                        n_rem = cpcm_pkg::MA_W'(rem_c - cpcm_pkg::CHG_WRAP);
                    end else begin
                        n_quo = quo_c;
                        n_rem = cpcm_pkg::MA_W'(rem_c);
                    end
                end
                cpcm_pkg::FUNC_BLINK: begin
                    n_phase = phase_inc;
                    if (phase_inc[0]) begin
                        n_led = 1'b0;
                    end else if (phase_inc[cpcm_pkg::BLINK_W-1:1] <=
                                 (cpcm_pkg::BLINK_W-1)'(r_div)) begin
                        n_led   = 1'b1;
                        n_pause = '0;
                    end else begin
                        n_pause = pause_inc;
                        n_led   = 1'b0;
                        if (pause_inc >= cpcm_pkg::PAUSE_TICKS) begin
                            n_phase = '0;
                        end
                    end
                end
                cpcm_pkg::FUNC_PRESS: begin
                    if (i_sel) begin
                        n_out_on = 1'b1;
                        n_led    = 1'b1;
                        n_below  = '0;
                    end
                end
                cpcm_pkg::FUNC_TOGGLE: begin
                    if (i_sel) begin
                        n_auto = !r_auto;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_div    <= '0;
            r_below  <= '0;
            r_auto   <= 1'b1;
            r_out_on <= 1'b1;
            r_led    <= 1'b1;
            r_quo    <= '0;
            r_rem    <= '0;
            r_phase  <= '0;
            r_pause  <= '0;
        end else begin
            r_cur    <= n_cur;
            r_div    <= n_div;
            r_below  <= n_below;
            r_auto   <= n_auto;
            r_out_on <= n_out_on;
            r_led    <= n_led;
            r_quo    <= n_quo;
            r_rem    <= n_rem;
            r_phase  <= n_phase;
            r_pause  <= n_pause;
        end
    end

    // Status reflects the state after the current event.
    assign o_stat.out_on  = n_out_on;
    assign o_stat.led_on  = n_led;
    assign o_stat.auto_on = n_auto;
    assign o_stat.current = n_cur;
    assign o_stat.charge  = n_quo;

    `CPCM_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_rem} < cpcm_pkg::CHG_DIV) &&
        (r_quo != cpcm_pkg::CHG_QMAX || {1'b0, r_rem} < cpcm_pkg::CHG_WRAP),
        "charge remainder out of range")
    `CPCM_ASSERT_NEXT(a_press_restores, i_clk, i_rst_n,
        i_evt.step && i_sel && i_evt.func == cpcm_pkg::FUNC_PRESS,
        r_out_on && r_led && r_below == '0,
        "press did not restore port")
    `CPCM_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_evt.step,
        $stable(r_below) && $stable(r_quo) && $stable(r_rem) && $stable(r_phase),
        "lane state changed without an event")

endmodule

`default_nettype wire

// File: hw/rtl/charge_port_current_monitor_top.sv
// Charge port current monitor for three charging ports.
// Events enter on the s_axis stream: tuser carries the event kind and the
// port, tdata the raw 12-bit converter reading used by sample events. Each
// accepted beat produces exactly one status beat on m_axis, carrying the
// output-enable, LED and auto-mode bits of all ports plus the current and
// charge (mAh) of the selected port, all taken after the event is applied.
// Thresholds are set through the write port (index 0 cut current in mA,
// index 1 cut tick count); write them only while no event is in flight.
// The status beat is registered: the accepting edge loads the input
// register, and the per-port lane update then runs into the output register
// once that register is free or being emptied. All ports update in parallel,
// so one beat is taken every cycle while the receiver keeps up, set by the
// single lane update per event.
// When the receiver stalls, the status beat holds in the output register
// while one more event waits in the input register; s_axis_tready drops
// only once both are full. Reset (synchronous, active low) empties both
// stages, restores the threshold defaults and puts every port in its power
// up state: output on, LED lit, auto cut on, counters and charge cleared.
`default_nettype none
`include "charge_port_current_monitor_top_defines.svh"

module charge_port_current_monitor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [11:0] adc_sample
    input  wire logic [4:0]  s_axis_tuser,   // [2:0] func, [4:3] port
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] out_enables, [5:3] led_states, [8:6] auto_modes,
    // [20:9] current_ma, [41:21] charge_mah
    output logic [47:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [cpcm_pkg::CFG_IW-1:0] i_cfg_idx,
    input  wire logic [cpcm_pkg::CFG_W-1:0]  i_cfg_wdata
);

    // Configuration registers.
    logic [cpcm_pkg::MA_W-1:0]  r_cut_ma;
    logic [cpcm_pkg::CNT_W-1:0] r_cut_ticks;

    // Input stage.
    logic                          r_in_valid;
    cpcm_pkg::t_func               r_func;
    logic [cpcm_pkg::PORT_W-1:0]   r_port;
    logic [cpcm_pkg::ADC_W-1:0]    r_adc;

    // Output stage.
    logic                          r_out_valid;
    logic [cpcm_pkg::STAT_BITS-1:0] r_en, n_en;
    logic [cpcm_pkg::STAT_BITS-1:0] r_led, n_led;
    logic [cpcm_pkg::STAT_BITS-1:0] r_am, n_am;
    logic [cpcm_pkg::MA_W-1:0]      r_cur, n_cur;
    logic [cpcm_pkg::QUO_W-1:0]     r_chg, n_chg;

    logic                          adv;
    logic [cpcm_pkg::MA_PW-1:0]    ma_prod;
    logic [cpcm_pkg::DIV_PW-1:0]   div_prod;
    cpcm_pkg::t_lane_evt           evt;
    cpcm_pkg::t_lane_stat          stat [cpcm_pkg::NUM_PORTS];
    logic [cpcm_pkg::NUM_PORTS-1:0] sel;

    // The event in the input register completes when the output register
    // is free or being emptied this cycle.
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_ma    <= cpcm_pkg::CUT_MA_RST;
            r_cut_ticks <= cpcm_pkg::CUT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (cpcm_pkg::t_cfg_reg'(i_cfg_idx))
                cpcm_pkg::CFG_CUT_MA:    r_cut_ma    <= i_cfg_wdata[cpcm_pkg::MA_W-1:0];
                cpcm_pkg::CFG_CUT_TICKS: r_cut_ticks <= i_cfg_wdata[cpcm_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= cpcm_pkg::t_func'(s_axis_tuser[cpcm_pkg::FUNC_W-1:0]);
            r_port <= s_axis_tuser[cpcm_pkg::FUNC_W +: cpcm_pkg::PORT_W];
            r_adc  <= s_axis_tdata[cpcm_pkg::ADC_W-1:0];
        end
    end

    // Scaling: one constant product each for mA and for the blink count.
    assign ma_prod  = cpcm_pkg::MA_PW'(r_adc) * cpcm_pkg::MA_PW'(cpcm_pkg::MA_MUL);
    assign div_prod = cpcm_pkg::DIV_PW'(r_adc) * cpcm_pkg::DIV_PW'(cpcm_pkg::DIV_MUL);

    assign evt.step      = adv;
    assign evt.func      = r_func;
    assign evt.ma        = ma_prod[cpcm_pkg::MA_PW-1:cpcm_pkg::MA_SHIFT];
    assign evt.div       = div_prod[cpcm_pkg::DIV_PW-1:cpcm_pkg::DIV_SHIFT];
    assign evt.cut_ma    = r_cut_ma;
    assign evt.cut_ticks = r_cut_ticks;

    for (genvar g = 0; g < cpcm_pkg::NUM_PORTS; g++) begin : g_lane
        assign sel[g] = ({1'b0, r_port} == (cpcm_pkg::PORT_W + 1)'(g));

        cpcm_port_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_evt   (evt),
            .i_sel   (sel[g]),
            .o_stat  (stat[g])
        );
    end

    // Gather status; a port index outside the lanes reports zero current and charge.
    always_comb begin
        n_en  = '0;
        n_led = '0;
        n_am  = '0;
        n_cur = '0;
        n_chg = '0;
        for (int i = 0; i < cpcm_pkg::NUM_PORTS; i++) begin
            if (i < cpcm_pkg::STAT_BITS) begin
                n_en[i]  = stat[i].out_on;
                n_led[i] = stat[i].led_on;
                n_am[i]  = stat[i].auto_on;
            end
            if (sel[i]) begin
                n_cur = stat[i].current;
                n_chg = stat[i].charge;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_en  <= n_en;
            r_led <= n_led;
            r_am  <= n_am;
            r_cur <= n_cur;
            r_chg <= n_chg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_chg, r_cur, r_am, r_led, r_en};

    `CPCM_ASSERT_NEXT(a_step_fills_out, i_clk, i_rst_n, adv, r_out_valid,
        "completed event produced no status beat")
    `CPCM_ASSERT_NEXT(a_in_holds, i_clk, i_rst_n, r_in_valid && !adv,
        r_in_valid && $stable(r_adc) && $stable(r_port),
        "pending event lost from input register")

endmodule

`default_nettype wire
